@@ sv/base32_to_base64_transcoder_unit_defines.svh @@
// Assertion macros for the base32 to base64 transcoder.
`ifndef BASE32_TO_BASE64_TRANSCODER_UNIT_DEFINES_SVH
`define BASE32_TO_BASE64_TRANSCODER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define B32B64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define B32B64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/b32b64_pkg.sv @@
// Package: types, constants and the base64 symbol function of the transcoder.
`default_nettype none
package b32b64_pkg;

  localparam int unsigned MaxRes  = 7;     // most beats one input can cause
  localparam int unsigned ResCntW = 3;
  localparam int unsigned StoreW  = 11;    // at most 11 unsent bits remain

  localparam logic [7:0] ChUpA    = 8'd65;
  localparam logic [7:0] ChUpZ    = 8'd90;
  localparam logic [7:0] ChDig2   = 8'd50;
  localparam logic [7:0] ChDig7   = 8'd55;
  localparam logic [7:0] DigitOfs = 8'd24;
  localparam logic [7:0] LowOfs   = 8'd71;
  localparam logic [7:0] NumOfs   = 8'd4;
  localparam logic [7:0] ChPlus   = 8'd43;
  localparam logic [7:0] ChSlash  = 8'd47;
  localparam logic [7:0] ChPad    = 8'd61;
  localparam logic [7:0] ChNl     = 8'd10;

  typedef struct packed {
    logic [StoreW-1:0] store;
    logic [3:0]        held;
    logic [2:0]        phase;
    logic [1:0]        count;
  } state_t;

  typedef struct packed {
    logic [ResCntW-1:0]          num;
    logic [MaxRes-1:0][7:0]      chars;
    logic                        ends;   // final beat is the closing newline
  } res_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)       return w + ChUpA;
    else if (v < 6'd52)  return w + LowOfs;
    else if (v < 6'd62)  return w - NumOfs;
    else if (v == 6'd62) return ChPlus;
    else                 return ChSlash;
  endfunction

endpackage
`default_nettype wire

@@ sv/b32b64_if.sv @@
// Valid/ready channel interfaces for input characters and output characters.
`default_nettype none
interface b32b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;
  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b32b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

@@ sv/base32_to_base64_transcoder_unit.sv @@
// Top level of the base32 to base64 transcoder.
`default_nettype none
// Takes one base32 character per input beat ('A'-'Z' and '2'-'7'; any other
// byte is dropped) and produces standard base64 characters. The 5-bit
// symbols form a bit stream; a 6-bit group goes out once it lies wholly in
// completed bytes. The beat flagged in_last closes the string: leftover bits
// of completed bytes go out as one zero-filled group, then '=' up to a
// multiple of four characters, then a newline with out_last set; bits of an
// unfinished byte are discarded. Input and output are valid/ready; an input
// beat is registered, then processed combinationally into a result buffer
// of up to seven characters, which drains at one character per cycle while
// the output is ready. The input register can take a new beat while the
// previous one's characters go out; that beat then waits: an input causing
// k output characters occupies the result buffer until all k have gone out;
// an input causing none still waits until the buffer sends its last
// character, then moves on in that same cycle. Between input accept and the
// first output beat lie the input register and then the result register.
module base32_to_base64_transcoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  b32b64_in_if.sink    in_i,
  b32b64_out_if.source out_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // packing state carried between characters
  b32b64_pkg::state_t state_q, state_d;
  b32b64_pkg::res_t   res;

  logic free, adv, take;

  // the registered beat moves on when the result buffer can take it
  assign adv     = in_vld_q && free;
  assign in_i.ready = !in_vld_q || free;
  assign take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_char_q <= in_i.in_char;
      in_last_q <= in_i.in_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  b32b64_core u_core (
    .state_i (state_q),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // characters that add no output skip the buffer
  b32b64_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv && (res.num != 3'd0)),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

@@ sv/b32b64_core.sv @@
// Single-pass datapath: decode, pack, cut groups and build the beat list.
`default_nettype none
module b32b64_core (
  input  b32b64_pkg::state_t state_i,
  input  logic [7:0]         char_i,
  input  logic               last_i,
  output b32b64_pkg::state_t state_o,
  output b32b64_pkg::res_t   res_o
);

  logic        sym_ok;
  logic [4:0]  sym;
  logic [15:0] s1, sf, tail;
  logic [4:0]  h1, h2, h3, lim, rem;
  logic [2:0]  p1;
  logic        g0_en, g1_en, fin_en;
  logic [5:0]  g0, g1, gf;
  logic [1:0]  c1, c2, pads;
  logic [2:0]  n;

  always_comb begin
    sym_ok = 1'b1;
    sym    = '0;
    if (char_i inside {[b32b64_pkg::ChUpA:b32b64_pkg::ChUpZ]}) begin
      sym = 5'(char_i - b32b64_pkg::ChUpA);
    end else if (char_i inside {[b32b64_pkg::ChDig2:b32b64_pkg::ChDig7]}) begin
      sym = 5'(char_i - b32b64_pkg::DigitOfs);
    end else begin
      sym_ok = 1'b0;
    end
  end

  // append five bits for a valid symbol
  assign s1  = sym_ok ? (16'({5'd0, state_i.store} << 5) | 16'(sym))
                      : 16'(state_i.store);
  assign h1  = {1'b0, state_i.held} + (sym_ok ? 5'd5 : 5'd0);
  assign p1  = state_i.phase + (sym_ok ? 3'd5 : 3'd0);
  assign lim = {2'b00, p1} + 5'd6;

  // at most two groups can complete per character
  assign g0_en = h1 >= lim;
  assign g0    = 6'(s1 >> (h1 - 5'd6));
  assign h2    = g0_en ? h1 - 5'd6 : h1;
  assign g1_en = g0_en && (h2 >= lim);
  assign g1    = 6'(s1 >> (h2 - 5'd6));
  assign h3    = g1_en ? h2 - 5'd6 : h2;
  assign sf    = s1 & ((16'd1 << h3) - 16'd1);
  assign c1    = state_i.count + {1'b0, g0_en} + {1'b0, g1_en};

  // final zero-filled group from completed bytes only
  assign rem    = h3 - {2'b00, p1};
  assign fin_en = last_i && (rem != 5'd0);
  assign tail   = (sf >> p1) & ((16'd1 << rem) - 16'd1);
  assign gf     = tail[5:0] << (3'd6 - rem[2:0]);
  assign c2     = c1 + {1'b0, fin_en};
  assign pads   = 2'd0 - c2;

  always_comb begin
    res_o.chars = '0;
    n           = '0;
    if (g0_en) begin
      res_o.chars[n] = b32b64_pkg::b64_char(g0);
      n = n + 3'd1;
    end
    if (g1_en) begin
      res_o.chars[n] = b32b64_pkg::b64_char(g1);
      n = n + 3'd1;
    end
    if (last_i) begin
      if (fin_en) begin
        res_o.chars[n] = b32b64_pkg::b64_char(gf);
        n = n + 3'd1;
      end
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pads) begin
          res_o.chars[n] = b32b64_pkg::ChPad;
          n = n + 3'd1;
        end
      end
      res_o.chars[n] = b32b64_pkg::ChNl;
      n = n + 3'd1;
    end
    res_o.num  = n;
    res_o.ends = last_i;
  end

  always_comb begin
    if (last_i) begin
      state_o = '0;
    end else begin
      state_o.store = sf[b32b64_pkg::StoreW-1:0];
      state_o.held  = h3[3:0];
      state_o.phase = p1;
      state_o.count = c1;
    end
  end

endmodule
`default_nettype wire

@@ sv/b32b64_emit.sv @@
// Result register and serializer: sends the buffered beats one per cycle while the output is ready.
`default_nettype none
`include "base32_to_base64_transcoder_unit_defines.svh"
module b32b64_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  b32b64_pkg::res_t     res_i,
  output logic                 free_o,
  b32b64_out_if.source         out_o
);

  b32b64_pkg::res_t                   res_q;
  logic [b32b64_pkg::ResCntW-1:0]     idx_q;
  logic                               busy_q;
  logic                               fire, final_beat;

  assign final_beat = idx_q == (res_q.num - 3'd1);
  assign fire       = busy_q && out_o.ready;
  assign free_o     = !busy_q || (fire && final_beat);

  assign out_o.valid    = busy_q;
  assign out_o.out_char = res_q.chars[idx_q];
  assign out_o.out_last = res_q.ends && final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      if (final_beat) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  `B32B64_ASSERT(a_load_free, load_i |-> free_o && (res_i.num != 3'd0), "load into busy buffer")
  `B32B64_ASSERT(a_idx_range, busy_q |-> idx_q < res_q.num, "beat index past count")
  `B32B64_ASSERT(a_last_nl, out_o.valid && out_o.out_last |-> out_o.out_char == b32b64_pkg::ChNl, "last beat not newline")
  `B32B64_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !busy_q, "busy after reset")

endmodule
`default_nettype wire
